// File: rtl/stl_pkg.sv
// Shared types, widths and codes for the symbol table lookup block.
// No dependencies; every other file of the block imports this package.
package stl_pkg;

    localparam int DEFAULT_ENTRIES = 32;

    localparam int OP_W     = 3;
    localparam int LABEL_W  = 64;
    localparam int ADDR_W   = 24;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Request codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_RENAME = 3'd4;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // One slot of the table memory.
    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
        logic [ADDR_W-1:0]  addr;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the request beat into the working registers
        logic sweep;      // invalidate the slot at the sweep index and step it
        logic read;       // read the slot at the scan index and step it
        logic insert_wr;  // write the new entry into the first free slot
        logic load_out;   // load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_idx;   // the index points at the last slot
    } dp_status_t;

endpackage

// File: rtl/stl_ctrl.sv
// Controller state machine of the symbol table lookup block.
// Depends on stl_pkg for the command and status structs.
module stl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                is_clear,
    input  logic                out_stall,
    input  stl_pkg::dp_status_t stat,
    output stl_pkg::ctrl_cmd_t  cmd,
    output logic                in_stall,
    output logic                out_valid
);
    import stl_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CLEAR  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (stat.last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = is_clear ? S_CLEAR : S_SCAN;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.last_idx)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.read = 1'b1;
                if (stat.last_idx)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert_wr = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/stl_datapath.sv
// Datapath of the symbol table lookup block: table memory, scan compare,
// entry count and result register. Depends on stl_pkg.
module stl_datapath #(
    parameter int ENTRIES = stl_pkg::DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stl_pkg::ctrl_cmd_t           cmd,
    output stl_pkg::dp_status_t          stat,
    input  logic [stl_pkg::OP_W-1:0]     operation,
    input  logic [stl_pkg::LABEL_W-1:0]  label,
    input  logic [stl_pkg::ADDR_W-1:0]   address,
    input  logic [stl_pkg::LABEL_W-1:0]  new_label,
    output logic [stl_pkg::STATUS_W-1:0] status,
    output logic                         found,
    output logic [stl_pkg::ADDR_W-1:0]   address_out,
    output logic [stl_pkg::COUNT_W-1:0]  entry_count
);
    import stl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    entry_t mem [ENTRIES];

    logic [OP_W-1:0]     op_reg;
    logic [LABEL_W-1:0]  label_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LABEL_W-1:0]  nlabel_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    entry_t              rd_data_reg;

    logic                hit_reg;
    logic [ADDR_W-1:0]   hit_addr_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [STATUS_W-1:0] status_reg;
    logic                found_reg;
    logic [ADDR_W-1:0]   addr_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic                match;
    logic                is_free;
    logic                do_insert;
    logic                do_delete;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    entry_t              wr_data;
    logic [STATUS_W-1:0] status_next;

    assign stat.last_idx = (idx_reg == LAST_IDX);

    assign match     = cmp_valid_reg && rd_data_reg.valid && (rd_data_reg.label == label_reg);
    assign is_free   = cmp_valid_reg && !rd_data_reg.valid;
    assign do_insert = (op_reg == OP_INSERT) && !hit_reg && free_found_reg;
    assign do_delete = match && (op_reg == OP_DELETE) && !hit_reg;

    // Write port: sweep, insert, or write-back of the slot just compared.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = cmp_idx_reg;
        wr_data = rd_data_reg;
        priority if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_idx  = idx_reg;
            wr_data = '0;
        end
        else if (cmd.insert_wr)
        begin
            wr_en         = do_insert;
            wr_idx        = free_idx_reg;
            wr_data.valid = 1'b1;
            wr_data.label = label_reg;
            wr_data.addr  = addr_reg;
        end
        else if (match)
        begin
            unique case (op_reg)
                OP_RENAME:
                begin
                    wr_en         = 1'b1;
                    wr_data.label = nlabel_reg;
                end
                OP_CHANGE:
                begin
                    wr_en        = 1'b1;
                    wr_data.addr = addr_reg;
                end
                OP_DELETE:
                begin
                    wr_en         = !hit_reg;
                    wr_data.valid = 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Request and scan payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= operation;
            label_reg  <= label;
            addr_reg   <= address;
            nlabel_reg <= new_label;
        end
        cmp_idx_reg <= idx_reg;
        if (match && !hit_reg)
        begin
            hit_addr_reg <= rd_data_reg.addr;
        end
        if (is_free && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmd.read;
            if (cmd.sweep || cmd.read)
            begin
                idx_reg <= stat.last_idx ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.capture)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (is_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            priority if (cmd.sweep)
            begin
                count_reg <= '0;
            end
            else if (cmd.insert_wr && do_insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_delete)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else
            begin
                count_reg <= count_reg;
            end
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_CLEAR:
            begin
                status_next = ST_OK;
            end
            OP_INSERT:
            begin
                status_next = hit_reg ? ST_PRESENT : (free_found_reg ? ST_OK : ST_FULL);
            end
            default:
            begin
                status_next = hit_reg ? ST_OK : ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg    <= status_next;
            found_reg     <= (op_reg != OP_CLEAR) && hit_reg;
            addr_out_reg  <= ((op_reg != OP_CLEAR) && hit_reg) ? hit_addr_reg : '0;
            count_out_reg <= COUNT_W'(count_reg);
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign address_out = addr_out_reg;
    assign entry_count = count_out_reg;

endmodule

// File: rtl/symbol_table_lookup.sv
// Top level of the symbol table lookup block: controller plus datapath.
// Depends on stl_pkg, stl_ctrl and stl_datapath.
//
//  channel | beat moved                             | handshake
//  --------+----------------------------------------+---------------------
//  in      | operation, label, address, new_label   | in_valid / in_stall
//  out     | status, found, address_out, entry_count | out_valid / out_stall
//
// A request runs from accept to the next accept in these steps: accept,
// a scan reading one slot per cycle from the table memory, compare of the
// last slot, insert write and the result load, which waits while an
// earlier result is still stalled. A clear runs accept, a sweep writing one
// slot per cycle and the result load. After reset the block sweeps the
// table with in_stall high before it takes the first beat.
// A result waiting in the output register does not hold off the next
// request; only a second result stalls until the first one is taken.
module symbol_table_lookup #(
    parameter int ENTRIES = stl_pkg::DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [stl_pkg::OP_W-1:0]     operation,
    input  logic [stl_pkg::LABEL_W-1:0]  label,
    input  logic [stl_pkg::ADDR_W-1:0]   address,
    input  logic [stl_pkg::LABEL_W-1:0]  new_label,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [stl_pkg::STATUS_W-1:0] status,
    output logic                         found,
    output logic [stl_pkg::ADDR_W-1:0]   address_out,
    output logic [stl_pkg::COUNT_W-1:0]  entry_count
);
    import stl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic       is_clear;

    // The controller only needs to know whether the request is a clear,
    // which runs a sweep instead of a scan.
    assign is_clear = (operation == OP_CLEAR);

    stl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_clear  (is_clear),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    stl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .label       (label),
        .address     (address),
        .new_label   (new_label),
        .status      (status),
        .found       (found),
        .address_out (address_out),
        .entry_count (entry_count)
    );

    // The block is busy the cycle after it accepts a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while the previous one is still running");

    // A sweep of the table never runs while requests are accepted.
    a_sweep_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> in_stall)
        else $error("table sweep while the input side is open");

    // Loading the result register always presents a result.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result loaded but not presented");

    // A found label never reports absent or full.
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK || status == ST_PRESENT))
        else $error("found label with an absent or full status");

endmodule
